// ----- design/slh_pkg.sv -----
package slh_pkg;

	localparam int CORDIC_STEPS_DEF = 32;

	// Field widths.
	localparam int LAT_W = 28;
	localparam int LON_W = 29;
	localparam int LEN_W = 32;

	// Angles in half-microdegree units and their reduced forms.
	localparam int U_W   = 31;
	localparam int R_W   = 30;
	localparam int MAG_W = 28;
	localparam int ZM_W  = 31;

	localparam logic signed [U_W-1:0] FULL_TURN_U    = 31'sd720000000;
	localparam logic signed [U_W-1:0] HALF_TURN_U    = 31'sd360000000;
	localparam logic signed [U_W-1:0] QUARTER_TURN_U = 31'sd180000000;

	// Radians per half microdegree in Q2.62, split for two narrow multipliers.
	localparam int         K_W      = 36;
	localparam int         K_SPLIT  = 18;
	localparam logic [K_W-1:0] RAD_K = 36'd40244552545;
	localparam logic [K_SPLIT-1:0]     RAD_K_LO = RAD_K[K_SPLIT-1:0];
	localparam logic [K_W-K_SPLIT-1:0] RAD_K_HI = RAD_K[K_W-1:K_SPLIT];
	localparam int PP_W = MAG_W + K_SPLIT;
	localparam int ZP_W = MAG_W + K_W;

	// CORDIC datapath and clamped Q2.30 values.
	localparam int CW = 36;
	localparam int QW = 32;
	localparam logic signed [CW-1:0] CORDIC_GAIN = 36'sd652032874;
	localparam logic signed [CW-1:0] Q_ONE_C     = 36'sd1073741824;
	localparam logic signed [QW-1:0] Q_ONE       = 32'sd1073741824;

	// Haversine value and square roots.
	localparam int H_W      = 31;
	localparam logic [H_W-1:0] H_ONE = 31'd1073741824;
	localparam int SQ_STEPS = 31;
	localparam int SQ_IN_W  = 2 * SQ_STEPS;
	localparam int ROOT_W   = 31;
	localparam int REM_W    = 34;

	localparam int ER_W = 30;
	localparam logic [ER_W-1:0] EARTH_RADIUS_CM = 30'd637100000;

	typedef enum logic [1:0] {
		LEG_ROOT,
		LEG_NORMAL,
		LEG_DEVIATION
	} leg_t;

	typedef struct packed {
		leg_t leg;
		logic ok;
	} tag_t;

	// atan(2^-i) in Q2.30.
	function automatic logic signed [CW-1:0] atan_q(input int i);
		logic signed [CW-1:0] r;
		case (i)
			0: r = 36'sd843314857;
			1: r = 36'sd497837829;
			2: r = 36'sd263043837;
			3: r = 36'sd133525159;
			4: r = 36'sd67021687;
			5: r = 36'sd33543516;
			6: r = 36'sd16775851;
			7: r = 36'sd8388437;
			8: r = 36'sd4194283;
			9: r = 36'sd2097149;
			default: r = (i <= 30) ? (36'sd1 <<< (30 - i)) : '0;
		endcase
		return r;
	endfunction

	function automatic logic signed [QW-1:0] clampq(input logic signed [CW-1:0] v);
		logic signed [QW-1:0] r;
		if (v > Q_ONE_C) r = Q_ONE;
		else if (v < -Q_ONE_C) r = -Q_ONE;
		else r = QW'(v);
		return r;
	endfunction

	// Q2.30 product, rounded half away from zero.
	function automatic logic signed [QW-1:0] mulq(input logic signed [QW-1:0] a,
		input logic signed [QW-1:0] b);
		logic [QW-1:0]   ma;
		logic [QW-1:0]   mb;
		logic [2*QW-1:0] p;
		logic [QW-1:0]   r;
		ma = a[QW-1] ? QW'(-a) : QW'(a);
		mb = b[QW-1] ? QW'(-b) : QW'(b);
		p = (2*QW)'(ma) * (2*QW)'(mb) + ((2*QW)'(1) << 29);
		r = p[QW+29:30];
		return (a[QW-1] ^ b[QW-1]) ? -$signed(r) : $signed(r);
	endfunction

endpackage

// ----- design/slh_in_if.sv -----
interface slh_in_if;
	logic valid;
	logic ready;
	logic signed [slh_pkg::LAT_W-1:0] junction_lat;
	logic signed [slh_pkg::LON_W-1:0] junction_lon;
	logic signed [slh_pkg::LAT_W-1:0] root_lat;
	logic signed [slh_pkg::LON_W-1:0] root_lon;
	logic signed [slh_pkg::LAT_W-1:0] normal_lat;
	logic signed [slh_pkg::LON_W-1:0] normal_lon;
	logic signed [slh_pkg::LAT_W-1:0] deviation_lat;
	logic signed [slh_pkg::LON_W-1:0] deviation_lon;
	logic oriented;
	logic root_present;
	logic normal_present;
	logic deviation_present;

	modport source (output valid, junction_lat, junction_lon, root_lat, root_lon,
		normal_lat, normal_lon, deviation_lat, deviation_lon, oriented, root_present,
		normal_present, deviation_present, input ready);
	modport sink (input valid, junction_lat, junction_lon, root_lat, root_lon,
		normal_lat, normal_lon, deviation_lat, deviation_lon, oriented, root_present,
		normal_present, deviation_present, output ready);
endinterface

// ----- design/slh_out_if.sv -----
interface slh_out_if;
	logic valid;
	logic ready;
	logic [slh_pkg::LEN_W-1:0] total_length_cm;
	logic length_valid;

	modport source (output valid, total_length_cm, length_valid, input ready);
	modport sink (input valid, total_length_cm, length_valid, output ready);
endinterface

// ----- design/switch_length_haversine.sv -----
// The three legs of a request share one distance pipeline that takes one leg per cycle
// while the output is not stalled; a new request is taken as the deviation leg of the last one issues.
// The whole pipeline freezes while a finished result waits at the output.
// Reset (arst_n low, asynchronous) clears all valid flags; no clearing pass is needed.
module switch_length_haversine #(
	parameter int CORDIC_STEPS = slh_pkg::CORDIC_STEPS_DEF
) (
	input logic clk,
	input logic arst_n,
	slh_in_if.sink item,
	slh_out_if.source result
);

	logic hold_q;
	slh_pkg::leg_t leg_q;
	logic signed [slh_pkg::LAT_W-1:0] j_lat_q, r_lat_q, n_lat_q, d_lat_q;
	logic signed [slh_pkg::LON_W-1:0] j_lon_q, r_lon_q, n_lon_q, d_lon_q;
	logic ok_q;

	logic adv, take, issue;
	logic signed [slh_pkg::LAT_W-1:0] lat_a, lat_b;
	logic signed [slh_pkg::LON_W-1:0] lon_a, lon_b;
	slh_pkg::tag_t tag_in;

	logic u_valid;
	slh_pkg::tag_t u_tag;
	logic [slh_pkg::LEN_W-1:0] u_leg;

	logic [slh_pkg::LEN_W-1:0] root_q, nrm_q, branch_c;
	logic [slh_pkg::LEN_W-1:0] total_q;
	logic lvalid_q, res_valid_q;

	assign adv = !res_valid_q || result.ready;
	assign take = item.valid && item.ready;
	assign issue = hold_q && adv;
	assign item.ready = !hold_q || (adv && leg_q == slh_pkg::LEG_DEVIATION);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b0;
			leg_q <= slh_pkg::LEG_ROOT;
		end else if (take) begin
			hold_q <= 1'b1;
			leg_q <= slh_pkg::LEG_ROOT;
		end else if (issue) begin
			case (leg_q)
				slh_pkg::LEG_ROOT: leg_q <= slh_pkg::LEG_NORMAL;
				slh_pkg::LEG_NORMAL: leg_q <= slh_pkg::LEG_DEVIATION;
				default: begin
					hold_q <= 1'b0;
					leg_q <= slh_pkg::LEG_ROOT;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			j_lat_q <= item.junction_lat;
			j_lon_q <= item.junction_lon;
			r_lat_q <= item.root_lat;
			r_lon_q <= item.root_lon;
			n_lat_q <= item.normal_lat;
			n_lon_q <= item.normal_lon;
			d_lat_q <= item.deviation_lat;
			d_lon_q <= item.deviation_lon;
			ok_q <= item.oriented && item.root_present && item.normal_present
				&& item.deviation_present;
		end
	end

	always_comb begin
		case (leg_q)
			slh_pkg::LEG_ROOT: begin
				lat_a = r_lat_q;
				lon_a = r_lon_q;
				lat_b = j_lat_q;
				lon_b = j_lon_q;
			end
			slh_pkg::LEG_NORMAL: begin
				lat_a = j_lat_q;
				lon_a = j_lon_q;
				lat_b = n_lat_q;
				lon_b = n_lon_q;
			end
			default: begin
				lat_a = j_lat_q;
				lon_a = j_lon_q;
				lat_b = d_lat_q;
				lon_b = d_lon_q;
			end
		endcase
		tag_in.leg = leg_q;
		tag_in.ok = ok_q;
	end

	slh_leg #(.STEPS(CORDIC_STEPS)) u_leg_unit (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.valid_in(hold_q),
		.tag_in(tag_in),
		.lat_a(lat_a),
		.lon_a(lon_a),
		.lat_b(lat_b),
		.lon_b(lon_b),
		.valid_out(u_valid),
		.tag_out(u_tag),
		.leg_cm(u_leg)
	);

	assign branch_c = (nrm_q > u_leg) ? nrm_q : u_leg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_valid_q <= 1'b0;
		else if (adv) res_valid_q <= u_valid && u_tag.leg == slh_pkg::LEG_DEVIATION;
	end

	// Legs arrive in request order: root, normal, then deviation closes the request.
	always_ff @(posedge clk) begin
		if (adv && u_valid) begin
			case (u_tag.leg)
				slh_pkg::LEG_ROOT: root_q <= u_leg;
				slh_pkg::LEG_NORMAL: nrm_q <= u_leg;
				default: begin
					total_q <= u_tag.ok ? root_q + branch_c : '0;
					lvalid_q <= u_tag.ok;
				end
			endcase
		end
	end

	assign result.valid = res_valid_q;
	assign result.total_length_cm = total_q;
	assign result.length_valid = lvalid_q;

endmodule

// ----- design/slh_sincos.sv -----
module slh_sincos #(
	parameter int STEPS = slh_pkg::CORDIC_STEPS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  logic valid_in,
	input  slh_pkg::tag_t tag_in,
	input  logic signed [slh_pkg::U_W-1:0] angle,
	output logic valid_out,
	output slh_pkg::tag_t tag_out,
	output logic signed [slh_pkg::QW-1:0] sine,
	output logic signed [slh_pkg::QW-1:0] cosine
);

	logic signed [slh_pkg::U_W-1:0] red_c;
	logic signed [slh_pkg::R_W-1:0] red_s1;
	logic v_s1;
	slh_pkg::tag_t tag_s1;

	logic signed [slh_pkg::U_W-1:0] fold_c;
	logic cneg_c;
	logic [slh_pkg::MAG_W-1:0] mag_s2;
	logic neg_s2, cneg_s2, v_s2;
	slh_pkg::tag_t tag_s2;

	logic [slh_pkg::PP_W-1:0] pph_s3, ppl_s3;
	logic neg_s3, cneg_s3, v_s3;
	slh_pkg::tag_t tag_s3;

	logic [slh_pkg::ZP_W-1:0] zp_c;
	logic [slh_pkg::ZM_W-1:0] zm_c;

	logic signed [slh_pkg::CW-1:0] cx_s [STEPS+1];
	logic signed [slh_pkg::CW-1:0] cy_s [STEPS+1];
	logic signed [slh_pkg::CW-1:0] cz_s [STEPS+1];
	logic cv_s [STEPS+1];
	logic cn_s [STEPS+1];
	slh_pkg::tag_t ct_s [STEPS+1];

	// One correction brings any difference of two legal coordinates into one turn.
	always_comb begin
		if (angle >= slh_pkg::HALF_TURN_U) red_c = angle - slh_pkg::FULL_TURN_U;
		else if (angle < -slh_pkg::HALF_TURN_U) red_c = angle + slh_pkg::FULL_TURN_U;
		else red_c = angle;
	end

	always_comb begin
		cneg_c = 1'b0;
		if (slh_pkg::U_W'(red_s1) > slh_pkg::QUARTER_TURN_U) begin
			fold_c = slh_pkg::HALF_TURN_U - slh_pkg::U_W'(red_s1);
			cneg_c = 1'b1;
		end else if (slh_pkg::U_W'(red_s1) < -slh_pkg::QUARTER_TURN_U) begin
			fold_c = -slh_pkg::HALF_TURN_U - slh_pkg::U_W'(red_s1);
			cneg_c = 1'b1;
		end else begin
			fold_c = slh_pkg::U_W'(red_s1);
		end
	end

	always_comb begin
		zp_c = {pph_s3, {slh_pkg::K_SPLIT{1'b0}}} + slh_pkg::ZP_W'(ppl_s3)
			+ (slh_pkg::ZP_W'(1) << 31);
		zm_c = zp_c[slh_pkg::ZM_W+31:32];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			cv_s[0] <= 1'b0;
		end else if (adv) begin
			v_s1 <= valid_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			cv_s[0] <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			red_s1 <= slh_pkg::R_W'(red_c);
			tag_s1 <= tag_in;
			mag_s2 <= fold_c[slh_pkg::U_W-1] ? slh_pkg::MAG_W'(-fold_c)
				: slh_pkg::MAG_W'(fold_c);
			neg_s2 <= fold_c[slh_pkg::U_W-1];
			cneg_s2 <= cneg_c;
			tag_s2 <= tag_s1;
			pph_s3 <= slh_pkg::PP_W'(mag_s2) * slh_pkg::PP_W'(slh_pkg::RAD_K_HI);
			ppl_s3 <= slh_pkg::PP_W'(mag_s2) * slh_pkg::PP_W'(slh_pkg::RAD_K_LO);
			neg_s3 <= neg_s2;
			cneg_s3 <= cneg_s2;
			tag_s3 <= tag_s2;
			cx_s[0] <= slh_pkg::CORDIC_GAIN;
			cy_s[0] <= '0;
			cz_s[0] <= neg_s3 ? -$signed(slh_pkg::CW'(zm_c)) : $signed(slh_pkg::CW'(zm_c));
			cn_s[0] <= cneg_s3;
			ct_s[0] <= tag_s3;
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_rot
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) cv_s[i+1] <= 1'b0;
			else if (adv) cv_s[i+1] <= cv_s[i];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				if (cz_s[i] >= 0) begin
					cx_s[i+1] <= cx_s[i] - (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] + (cx_s[i] >>> i);
					cz_s[i+1] <= cz_s[i] - slh_pkg::atan_q(i);
				end else begin
					cx_s[i+1] <= cx_s[i] + (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] - (cx_s[i] >>> i);
					cz_s[i+1] <= cz_s[i] + slh_pkg::atan_q(i);
				end
				cn_s[i+1] <= cn_s[i];
				ct_s[i+1] <= ct_s[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_out <= 1'b0;
		else if (adv) valid_out <= cv_s[STEPS];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sine <= slh_pkg::clampq(cy_s[STEPS]);
			cosine <= cn_s[STEPS] ? -slh_pkg::clampq(cx_s[STEPS])
				: slh_pkg::clampq(cx_s[STEPS]);
			tag_out <= ct_s[STEPS];
		end
	end

endmodule

// ----- design/slh_leg.sv -----
module slh_leg #(
	parameter int STEPS = slh_pkg::CORDIC_STEPS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  logic valid_in,
	input  slh_pkg::tag_t tag_in,
	input  logic signed [slh_pkg::LAT_W-1:0] lat_a,
	input  logic signed [slh_pkg::LON_W-1:0] lon_a,
	input  logic signed [slh_pkg::LAT_W-1:0] lat_b,
	input  logic signed [slh_pkg::LON_W-1:0] lon_b,
	output logic valid_out,
	output slh_pkg::tag_t tag_out,
	output logic [slh_pkg::LEN_W-1:0] leg_cm
);

	logic signed [slh_pkg::U_W-1:0] u_dlat, u_dlon, u_a, u_b;
	logic signed [slh_pkg::QW-1:0] s_lat, s_lon, c_a, c_b;
	logic sc_valid;
	slh_pkg::tag_t sc_tag;

	logic signed [slh_pkg::QW-1:0] p1_m1, p2_m1, p3_m1, p1_m2, p4_m2;
	logic v_m1, v_m2;
	slh_pkg::tag_t t_m1, t_m2;

	logic signed [slh_pkg::QW:0] hsum_c;
	logic [slh_pkg::H_W-1:0] h_c;

	// Lane 0 is sqrt(h), lane 1 is sqrt(1 - h).
	logic [slh_pkg::SQ_IN_W-1:0] sq_n_s [2][slh_pkg::SQ_STEPS+1];
	logic [slh_pkg::ROOT_W-1:0]  sq_r_s [2][slh_pkg::SQ_STEPS+1];
	logic [slh_pkg::REM_W-1:0]   sq_m_s [2][slh_pkg::SQ_STEPS+1];
	logic sq_v_s [slh_pkg::SQ_STEPS+1];
	slh_pkg::tag_t sq_t_s [slh_pkg::SQ_STEPS+1];
	logic [slh_pkg::ROOT_W-1:0] rnd_c [2];

	logic signed [slh_pkg::CW-1:0] vx_s [STEPS+1];
	logic signed [slh_pkg::CW-1:0] vy_s [STEPS+1];
	logic signed [slh_pkg::CW-1:0] vz_s [STEPS+1];
	logic vv_s [STEPS+1];
	slh_pkg::tag_t vt_s [STEPS+1];

	logic [slh_pkg::QW-1:0] half_c;
	logic [slh_pkg::QW+slh_pkg::ER_W-1:0] lp_c;

	assign u_dlat = slh_pkg::U_W'(lat_b) - slh_pkg::U_W'(lat_a);
	assign u_dlon = slh_pkg::U_W'(lon_b) - slh_pkg::U_W'(lon_a);
	assign u_a = slh_pkg::U_W'(lat_a) <<< 1;
	assign u_b = slh_pkg::U_W'(lat_b) <<< 1;

	slh_sincos #(.STEPS(STEPS)) u_sc_dlat (
		.clk(clk), .arst_n(arst_n), .adv(adv), .valid_in(valid_in), .tag_in(tag_in),
		.angle(u_dlat), .valid_out(sc_valid), .tag_out(sc_tag), .sine(s_lat), .cosine()
	);
	slh_sincos #(.STEPS(STEPS)) u_sc_dlon (
		.clk(clk), .arst_n(arst_n), .adv(adv), .valid_in(valid_in), .tag_in(tag_in),
		.angle(u_dlon), .valid_out(), .tag_out(), .sine(s_lon), .cosine()
	);
	slh_sincos #(.STEPS(STEPS)) u_sc_lat_a (
		.clk(clk), .arst_n(arst_n), .adv(adv), .valid_in(valid_in), .tag_in(tag_in),
		.angle(u_a), .valid_out(), .tag_out(), .sine(), .cosine(c_a)
	);
	slh_sincos #(.STEPS(STEPS)) u_sc_lat_b (
		.clk(clk), .arst_n(arst_n), .adv(adv), .valid_in(valid_in), .tag_in(tag_in),
		.angle(u_b), .valid_out(), .tag_out(), .sine(), .cosine(c_b)
	);

	always_comb begin
		hsum_c = (slh_pkg::QW+1)'(p1_m2) + (slh_pkg::QW+1)'(p4_m2);
		if (hsum_c < 0) h_c = '0;
		else if (hsum_c > (slh_pkg::QW+1)'(slh_pkg::Q_ONE)) h_c = slh_pkg::H_ONE;
		else h_c = slh_pkg::H_W'(hsum_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m1 <= 1'b0;
			v_m2 <= 1'b0;
			sq_v_s[0] <= 1'b0;
		end else if (adv) begin
			v_m1 <= sc_valid;
			v_m2 <= v_m1;
			sq_v_s[0] <= v_m2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p1_m1 <= slh_pkg::mulq(s_lat, s_lat);
			p2_m1 <= slh_pkg::mulq(c_a, c_b);
			p3_m1 <= slh_pkg::mulq(s_lon, s_lon);
			t_m1 <= sc_tag;
			p1_m2 <= p1_m1;
			p4_m2 <= slh_pkg::mulq(p2_m1, p3_m1);
			t_m2 <= t_m1;
			sq_n_s[0][0] <= slh_pkg::SQ_IN_W'({h_c, 30'b0});
			sq_n_s[1][0] <= slh_pkg::SQ_IN_W'({slh_pkg::H_ONE - h_c, 30'b0});
			sq_r_s[0][0] <= '0;
			sq_r_s[1][0] <= '0;
			sq_m_s[0][0] <= '0;
			sq_m_s[1][0] <= '0;
			sq_t_s[0] <= t_m2;
		end
	end

	// Restoring square root, one result bit per stage.
	for (genvar k = 0; k < slh_pkg::SQ_STEPS; k++) begin : g_sq
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sq_v_s[k+1] <= 1'b0;
			else if (adv) sq_v_s[k+1] <= sq_v_s[k];
		end

		always_ff @(posedge clk) begin
			if (adv) sq_t_s[k+1] <= sq_t_s[k];
		end

		for (genvar l = 0; l < 2; l++) begin : g_lane
			logic [slh_pkg::REM_W+1:0] cand;
			logic [slh_pkg::REM_W+1:0] trial;

			assign cand = {sq_m_s[l][k], sq_n_s[l][k][slh_pkg::SQ_IN_W-1-2*k -: 2]};
			assign trial = (slh_pkg::REM_W+2)'({sq_r_s[l][k], 2'b01});

			always_ff @(posedge clk) begin
				if (adv) begin
					sq_n_s[l][k+1] <= sq_n_s[l][k];
					if (cand >= trial) begin
						sq_m_s[l][k+1] <= slh_pkg::REM_W'(cand - trial);
						sq_r_s[l][k+1] <= {sq_r_s[l][k][slh_pkg::ROOT_W-2:0], 1'b1};
					end else begin
						sq_m_s[l][k+1] <= slh_pkg::REM_W'(cand);
						sq_r_s[l][k+1] <= {sq_r_s[l][k][slh_pkg::ROOT_W-2:0], 1'b0};
					end
				end
			end
		end
	end

	// Round to nearest: bump when the remainder exceeds the root.
	for (genvar l = 0; l < 2; l++) begin : g_rnd
		assign rnd_c[l] = sq_r_s[l][slh_pkg::SQ_STEPS]
			+ slh_pkg::ROOT_W'(sq_m_s[l][slh_pkg::SQ_STEPS]
			> slh_pkg::REM_W'(sq_r_s[l][slh_pkg::SQ_STEPS]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vv_s[0] <= 1'b0;
		else if (adv) vv_s[0] <= sq_v_s[slh_pkg::SQ_STEPS];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vx_s[0] <= slh_pkg::CW'(rnd_c[1]);
			vy_s[0] <= slh_pkg::CW'(rnd_c[0]);
			vz_s[0] <= '0;
			vt_s[0] <= sq_t_s[slh_pkg::SQ_STEPS];
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_vec
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vv_s[i+1] <= 1'b0;
			else if (adv) vv_s[i+1] <= vv_s[i];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				if (vy_s[i] >= 0) begin
					vx_s[i+1] <= vx_s[i] + (vy_s[i] >>> i);
					vy_s[i+1] <= vy_s[i] - (vx_s[i] >>> i);
					vz_s[i+1] <= vz_s[i] + slh_pkg::atan_q(i);
				end else begin
					vx_s[i+1] <= vx_s[i] - (vy_s[i] >>> i);
					vy_s[i+1] <= vy_s[i] + (vx_s[i] >>> i);
					vz_s[i+1] <= vz_s[i] - slh_pkg::atan_q(i);
				end
				vt_s[i+1] <= vt_s[i];
			end
		end
	end

	always_comb begin
		half_c = (vz_s[STEPS] < 0) ? '0 : slh_pkg::QW'(vz_s[STEPS]);
		lp_c = (slh_pkg::QW+slh_pkg::ER_W)'(half_c)
			* (slh_pkg::QW+slh_pkg::ER_W)'(slh_pkg::EARTH_RADIUS_CM)
			+ ((slh_pkg::QW+slh_pkg::ER_W)'(1) << 28);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_out <= 1'b0;
		else if (adv) valid_out <= vv_s[STEPS];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			leg_cm <= lp_c[slh_pkg::LEN_W+28:29];
			tag_out <= vt_s[STEPS];
		end
	end

endmodule

// ----- design/slh_checker.sv -----
module slh_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [slh_pkg::LEN_W-1:0] total_length_cm,
	input logic length_valid
);

	// A stalled result keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(total_length_cm)
			&& $stable(length_valid))
		else $error("result changed while stalled");

	// A result without a computed length carries a zero length.
	a_zero_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !length_valid |-> total_length_cm == '0)
		else $error("invalid length is not zero");

	// With the output stalled the block holds at most one new request.
	a_one_held: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && out_valid && !out_ready) ##1 (out_valid && !out_ready)
			|-> !in_ready)
		else $error("second request taken while output stalled");

	// An edge seen in reset leaves no result valid at the next edge.
	a_reset: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("result valid during reset");

endmodule

bind switch_length_haversine slh_checker u_slh_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(item.valid),
	.in_ready(item.ready),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.total_length_cm(result.total_length_cm),
	.length_valid(result.length_valid)
);

// ----- bench/tb_switch_length_haversine.sv -----
module tb_switch_length_haversine;

	localparam int STEPS = slh_pkg::CORDIC_STEPS_DEF;
	localparam int N_RANDOM = 600;
	localparam longint TURN = 720000000;
	localparam longint HALF = 360000000;
	localparam longint QUARTER = 180000000;
	localparam longint ONE_Q = 1073741824;
	localparam longint GAIN = 652032874;
	localparam longint unsigned RAD_PER_U = 64'd40244552545;
	localparam longint unsigned RADIUS_CM = 64'd637100000;

	typedef struct {
		logic signed [slh_pkg::LAT_W-1:0] j_lat, r_lat, n_lat, d_lat;
		logic signed [slh_pkg::LON_W-1:0] j_lon, r_lon, n_lon, d_lon;
		logic [3:0] flags; // oriented, root, normal, deviation
	} switch_req_t;

	typedef struct {
		logic [slh_pkg::LEN_W-1:0] length_cm;
		logic             computed;
	} length_t;

	typedef struct {
		switch_req_t req;
		bit          typed;
		length_t     want;
	} row_t;

	logic clk;
	logic arst_n;
	slh_in_if  item ();
	slh_out_if result ();

	switch_length_haversine uut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.result(result)
	);

	length_t expected_lengths[$];
	int      error_count = 0;
	bit      no_idle = 0;

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task automatic report(input string what);
		error_count++;
		$display("%0t mismatch: %s", $realtime, what);
	endtask

	function automatic longint arc_step(input int i);
		longint head[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
			33543516, 16775851, 8388437, 4194283, 2097149};
		if (i < 10) return head[i];
		if (i <= 30) return 64'sd1 <<< (30 - i);
		return 0;
	endfunction

	function automatic longint sat_one(input longint v);
		if (v > ONE_Q) return ONE_Q;
		if (v < -ONE_Q) return -ONE_Q;
		return v;
	endfunction

	// Product of two Q2.30 values, rounded half away from zero.
	function automatic longint qmul(input longint a, input longint b);
		longint unsigned ma, mb;
		longint r;
		ma = (a < 0) ? -a : a;
		mb = (b < 0) ? -b : b;
		r = longint'((ma * mb + (64'd1 << 29)) >> 30);
		return ((a < 0) != (b < 0)) ? -r : r;
	endfunction

	// Angle in half-microdegree units to sine and cosine by rotation CORDIC.
	function automatic void sin_cos(input longint u, output longint s, output longint c);
		longint r, z, x, y, dx, dy;
		longint unsigned mag;
		bit cneg;
		cneg = 0;
		r = u % TURN;
		if (r < 0) r += TURN;
		if (r >= HALF) r -= TURN;
		if (r > QUARTER) begin
			r = HALF - r;
			cneg = 1;
		end else if (r < -QUARTER) begin
			r = -HALF - r;
			cneg = 1;
		end
		mag = (r < 0) ? -r : r;
		z = longint'((mag * RAD_PER_U + (64'd1 << 31)) >> 32);
		if (r < 0) z = -z;
		x = GAIN;
		y = 0;
		for (int i = 0; i < STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= arc_step(i);
			end else begin
				x += dx; y -= dy; z += arc_step(i);
			end
		end
		s = sat_one(y);
		c = cneg ? -sat_one(x) : sat_one(x);
	endfunction

	function automatic longint half_angle(input longint ya, input longint xb);
		longint x, y, z, dx, dy;
		x = xb;
		y = ya;
		z = 0;
		for (int i = 0; i < STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; z += arc_step(i);
			end else begin
				x -= dx; y += dy; z -= arc_step(i);
			end
		end
		return (z < 0) ? 0 : z;
	endfunction

	function automatic longint unsigned root_round(input longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		if (n > r) r++;
		return r;
	endfunction

	function automatic longint unsigned leg_cm(input longint lat_a, input longint lon_a,
		input longint lat_b, input longint lon_b);
		longint s_lat, s_lon, c_a, c_b, unused, h, a, b;
		sin_cos(lat_b - lat_a, s_lat, unused);
		sin_cos(lon_b - lon_a, s_lon, unused);
		sin_cos(2 * lat_a, unused, c_a);
		sin_cos(2 * lat_b, unused, c_b);
		h = qmul(s_lat, s_lat) + qmul(qmul(c_a, c_b), qmul(s_lon, s_lon));
		if (h < 0) h = 0;
		if (h > ONE_Q) h = ONE_Q;
		a = root_round(longint'(h) << 30);
		b = root_round(longint'(ONE_Q - h) << 30);
		return (longint'(half_angle(a, b)) * RADIUS_CM + (64'd1 << 28)) >> 29;
	endfunction

	function automatic length_t switch_length(input switch_req_t q);
		length_t o;
		longint unsigned root, nrm, dev;
		o.length_cm = '0;
		o.computed = 1'b0;
		if (&q.flags) begin
			root = leg_cm(q.r_lat, q.r_lon, q.j_lat, q.j_lon);
			nrm = leg_cm(q.j_lat, q.j_lon, q.n_lat, q.n_lon);
			dev = leg_cm(q.j_lat, q.j_lon, q.d_lat, q.d_lon);
			o.length_cm = slh_pkg::LEN_W'(root + ((nrm > dev) ? nrm : dev));
			o.computed = 1'b1;
		end
		return o;
	endfunction

	function automatic switch_req_t make_req(input longint jla, jlo, rla, rlo,
		nla, nlo, dla, dlo, input logic [3:0] flags);
		switch_req_t q;
		q.j_lat = slh_pkg::LAT_W'(jla); q.j_lon = slh_pkg::LON_W'(jlo);
		q.r_lat = slh_pkg::LAT_W'(rla); q.r_lon = slh_pkg::LON_W'(rlo);
		q.n_lat = slh_pkg::LAT_W'(nla); q.n_lon = slh_pkg::LON_W'(nlo);
		q.d_lat = slh_pkg::LAT_W'(dla); q.d_lon = slh_pkg::LON_W'(dlo);
		q.flags = flags;
		return q;
	endfunction

	function automatic longint rand_lat();
		return longint'($urandom_range(180000000)) - 90000000;
	endfunction

	function automatic longint rand_lon();
		return longint'($urandom_range(360000000)) - 180000000;
	endfunction

	function automatic switch_req_t random_req();
		switch_req_t q;
		longint jla, jlo;
		int kind;
		kind = $urandom_range(99);
		jla = rand_lat();
		jlo = rand_lon();
		if (kind < 50) begin
			// A realistic switch: tips a few hundred meters from the junction.
			q = make_req(jla, jlo,
				jla + $signed($urandom_range(8000)) - 4000,
				jlo + $signed($urandom_range(8000)) - 4000,
				jla + $signed($urandom_range(8000)) - 4000,
				jlo + $signed($urandom_range(8000)) - 4000,
				jla + $signed($urandom_range(8000)) - 4000,
				jlo + $signed($urandom_range(8000)) - 4000,
				4'hf);
		end else if (kind < 80) begin
			q = make_req(jla, jlo, rand_lat(), rand_lon(), rand_lat(), rand_lon(),
				rand_lat(), rand_lon(), 4'hf);
		end else begin
			// Raw bit patterns, out-of-range angles included.
			q = make_req($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, 4'hf);
		end
		if ($urandom_range(99) < 15) q.flags = 4'($urandom);
		return q;
	endfunction

	task automatic send(input switch_req_t q);
		if (!no_idle && $urandom_range(99) < 15) begin
			item.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		item.valid <= 1'b1;
		item.junction_lat <= q.j_lat;
		item.junction_lon <= q.j_lon;
		item.root_lat <= q.r_lat;
		item.root_lon <= q.r_lon;
		item.normal_lat <= q.n_lat;
		item.normal_lon <= q.n_lon;
		item.deviation_lat <= q.d_lat;
		item.deviation_lon <= q.d_lon;
		{item.oriented, item.root_present, item.normal_present, item.deviation_present}
			<= q.flags;
		do @(posedge clk); while (!(item.valid && item.ready));
	endtask

	always @(posedge clk) begin
		if (arst_n && item.valid && item.ready) begin
			expected_lengths.push_back(switch_length(make_req(item.junction_lat,
				item.junction_lon, item.root_lat, item.root_lon, item.normal_lat,
				item.normal_lon, item.deviation_lat, item.deviation_lon,
				{item.oriented, item.root_present, item.normal_present,
				item.deviation_present})));
		end
	end

	always @(posedge clk) begin
		length_t want;
		if (arst_n && result.valid && result.ready) begin
			if (expected_lengths.size() == 0) begin
				report("result with no request outstanding");
			end else begin
				want = expected_lengths.pop_front();
				if (result.total_length_cm !== want.length_cm)
					report($sformatf("total_length_cm %0d, expected %0d",
						result.total_length_cm, want.length_cm));
				if (result.length_valid !== want.computed)
					report($sformatf("length_valid %0b, expected %0b",
						result.length_valid, want.computed));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) result.ready <= 1'b0;
		else result.ready <= no_idle || ($urandom_range(99) >= 15);
	end

	initial begin
		row_t rows[$];
		row_t r;
		length_t got;
		arst_n = 1'b0;
		item.valid = 1'b0;
		{item.junction_lat, item.junction_lon, item.root_lat, item.root_lon} = '0;
		{item.normal_lat, item.normal_lon, item.deviation_lat, item.deviation_lon} = '0;
		{item.oriented, item.root_present, item.normal_present, item.deviation_present} = '0;
		result.ready = 1'b0;

		// Unoriented or incomplete switches give a zero length, typed in directly.
		r.typed = 1;
		r.want.length_cm = '0;
		r.want.computed = 1'b0;
		r.req = make_req(1000, 2000, 1100, 2100, 1200, 2200, 1300, 2300, 4'b0111);
		rows.push_back(r);
		r.req.flags = 4'b1011; rows.push_back(r);
		r.req.flags = 4'b1101; rows.push_back(r);
		r.req.flags = 4'b1110; rows.push_back(r);
		r.req.flags = 4'b0000; rows.push_back(r);
		r.typed = 0;
		r.req = make_req(0, 0, 0, 0, 0, 0, 0, 0, 4'hf); rows.push_back(r);
		r.req = make_req(90000000, 180000000, -90000000, -180000000, 90000000, -180000000,
			-90000000, 180000000, 4'hf); rows.push_back(r);
		r.req = make_req(0, 0, 0, 180000000, 0, -180000000, 90000000, 0, 4'hf);
		rows.push_back(r);
		r.req = make_req(-134217728, -268435456, 134217727, 268435455, -134217728, 268435455,
			134217727, -268435456, 4'hf); rows.push_back(r);
		r.req = make_req(48856600, 2352200, 48857000, 2352000, 48856000, 2353000,
			48856100, 2353100, 4'hf); rows.push_back(r);
		r.req = make_req(-33868800, 151209300, -33868800, 151209301, -33868801, 151209300,
			-33868800, 151209300, 4'hf); rows.push_back(r);
		r.req = make_req(89999999, 0, 89999999, 179999999, 0, 90000000, 45000000, -90000000,
			4'hf); rows.push_back(r);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			if (rows[i].typed) begin
				got = switch_length(rows[i].req);
				if (got.length_cm !== rows[i].want.length_cm
					|| got.computed !== rows[i].want.computed)
					report($sformatf("predictor disagrees with table row %0d", i));
			end
			send(rows[i].req);
		end

		for (int n = 0; n < N_RANDOM; n++) begin
			no_idle = (n >= 200 && n < 350);
			if (n == 400) begin
				item.valid <= 1'b0;
				while (expected_lengths.size() != 0) @(posedge clk);
			end
			send(random_req());
		end
		item.valid <= 1'b0;
		no_idle = 0;

		while (expected_lengths.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
